[rtl/brenner_focus_measure_assert.svh]
// assertion helpers shared by the rtl modules
// the modules that use them have clk_i and rst_ni in scope
`ifndef BRENNER_FOCUS_MEASURE_ASSERT_SVH
`define BRENNER_FOCUS_MEASURE_ASSERT_SVH

// same-cycle implication
`define BFM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bfm_pkg.sv]
package bfm_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned PixelBits = 16;

  localparam int unsigned ColBits  = $clog2(MaxWidth);
  localparam int unsigned RowBits  = $clog2(MaxHeight);
  localparam int unsigned GeomBits = 13;
  localparam int unsigned DirBits  = 2;
  localparam int unsigned ExpBits  = 3;
  localparam int unsigned SqBits   = 2 * PixelBits;
  localparam int unsigned SumBits  = 64;
  localparam int unsigned DataBits = 16;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 13;

  typedef enum logic [CfgIdxBits-1:0] {
    RegFrameWidth    = 2'd0,
    RegFrameHeight   = 2'd1,
    RegDirectionMode = 2'd2,
    RegExponentPower = 2'd3
  } cfg_reg_e;

  localparam logic [DirBits-1:0] DirHoriz = 2'd0;
  localparam logic [DirBits-1:0] DirVert  = 2'd1;

  typedef struct packed {
    logic [GeomBits-1:0] frame_width;
    logic [GeomBits-1:0] frame_height;
    logic [DirBits-1:0]  direction_mode;
    logic [ExpBits-1:0]  exponent_power;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic diff;
    logic sq;
    logic pow;
    logic acc;
    logic wb;
    logic pass_v;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic out_blocked;
  } dp_status_t;

endpackage

[rtl/bfm_ctrl.sv]
`include "brenner_focus_measure_assert.svh"

module bfm_ctrl import bfm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SDiff = 6'b000010,
    SSq   = 6'b000100,
    SPow  = 6'b001000,
    SAcc  = 6'b010000,
    SWb   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;
  logic   s_fire;

  assign s_ready_o = (state_q == SIdle);
  assign s_fire    = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.pass_v = pass_q;
    unique case (state_q)
      SIdle: begin
        cmd_o.load = s_fire;
        if (s_fire) begin
          pass_d  = 1'b0;
          state_d = SDiff;
        end
      end
      SDiff: begin
        cmd_o.diff = 1'b1;
        state_d    = SSq;
      end
      SSq: begin
        cmd_o.sq = 1'b1;
        state_d  = SPow;
      end
      SPow: begin
        cmd_o.pow = 1'b1;
        state_d   = SAcc;
      end
      SAcc: begin
        cmd_o.acc = 1'b1;
        // horizontal term first, then vertical
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = SDiff;
        end else begin
          state_d = SWb;
        end
      end
      SWb: begin
        // hold the frame's last pixel until the result register is free
        if (!(st_i.frame_end && st_i.out_blocked)) begin
          cmd_o.wb = 1'b1;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  `BFM_ASSERT_NEXT(a_accept_starts_h, s_fire, (state_q == SDiff) && !pass_q, "request not started on horizontal pass")
  `BFM_ASSERT_NEXT(a_v_pass_ends_wb, (state_q == SAcc) && pass_q, state_q == SWb, "vertical pass not followed by writeback")
  `BFM_ASSERT_NEXT(a_wb_free_exits, (state_q == SWb) && !st_i.frame_end, state_q == SIdle, "writeback stalled without a result")

endmodule

[rtl/bfm_datapath.sv]
`include "brenner_focus_measure_assert.svh"

module bfm_datapath import bfm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           st_o,
  input  logic [DataBits-1:0]  pix_i,
  input  logic                 start_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [SumBits-1:0]   m_sum_o,
  output logic                 m_sat_o
);

  localparam logic [GeomBits-1:0] WidthTop  = GeomBits'(MaxWidth);
  localparam logic [GeomBits-1:0] HeightTop = GeomBits'(MaxHeight);
  localparam logic [GeomBits-1:0] GeomLow   = GeomBits'(3);

  logic [PixelBits-1:0] pix_q;
  logic [ColBits-1:0]   col_q, col_d;
  logic [RowBits-1:0]   row_q, row_d;
  logic [PixelBits-1:0] win_q [2];
  logic [SumBits-1:0]   acc_q;
  logic                 sat_q;

  logic [PixelBits-1:0] upper_mem  [MaxWidth];
  logic [PixelBits-1:0] middle_mem [MaxWidth];
  logic [PixelBits-1:0] up_rd_q, mid_rd_q;

  logic [PixelBits-1:0] d_q;
  logic                 en_q;
  logic [SqBits-1:0]    sq_q;
  logic [SumBits-1:0]   term_q;

  logic                 out_valid_q;
  logic [SumBits-1:0]   out_sum_q;
  logic                 out_sat_q;

  logic [GeomBits-1:0]  w_c, h_c;
  logic [ColBits-1:0]   wm1, wm2, c;
  logic [RowBits-1:0]   hm1, hm2, r;
  logic [ExpBits-1:0]   e_c;
  logic                 do_h, do_v, h_en, v_en, row_end, frame_end;
  logic [PixelBits-1:0] opnd;
  logic [SqBits-1:0]    mul_b;
  logic [SumBits-1:0]   prod, term_d;
  logic [SumBits:0]     sum_w;
  logic [SumBits-1:0]   acc_next;

  // geometry and exponent clamping
  always_comb begin
    if (cfg_i.frame_width < GeomLow)         w_c = GeomLow;
    else if (cfg_i.frame_width > WidthTop)   w_c = WidthTop;
    else                                     w_c = cfg_i.frame_width;
    if (cfg_i.frame_height < GeomLow)        h_c = GeomLow;
    else if (cfg_i.frame_height > HeightTop) h_c = HeightTop;
    else                                     h_c = cfg_i.frame_height;
    if (cfg_i.exponent_power == 3'd0)        e_c = 3'd1;
    else if (cfg_i.exponent_power > 3'd4)    e_c = 3'd4;
    else                                     e_c = cfg_i.exponent_power;
  end

  assign wm1 = ColBits'(w_c - GeomBits'(1));
  assign wm2 = ColBits'(w_c - GeomBits'(2));
  assign hm1 = RowBits'(h_c - GeomBits'(1));
  assign hm2 = RowBits'(h_c - GeomBits'(2));

  assign c = (col_q > wm1) ? wm1 : col_q;
  assign r = (row_q > hm1) ? hm1 : row_q;

  assign do_h = (cfg_i.direction_mode != DirVert);
  assign do_v = (cfg_i.direction_mode != DirHoriz);
  assign h_en = do_h && (c >= ColBits'(2)) && (r >= RowBits'(1)) && (r <= hm2);
  assign v_en = do_v && (c >= ColBits'(1)) && (c <= wm2) && (r >= RowBits'(2));

  assign row_end   = (c == wm1);
  assign frame_end = row_end && (r == hm1);

  assign st_o.frame_end   = frame_end;
  assign st_o.out_blocked = out_valid_q && !m_ready_i;

  // line stores: read on the horizontal pass, written back at the end of the pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff && !cmd_i.pass_v) begin
      up_rd_q  <= upper_mem[c];
      mid_rd_q <= middle_mem[c];
    end
    if (cmd_i.wb) begin
      upper_mem[c]  <= mid_rd_q;
      middle_mem[c] <= pix_q;
    end
  end

  // power unit: square, then one more multiply for cube and fourth power
  assign opnd  = cmd_i.pass_v ? up_rd_q : win_q[1];
  assign mul_b = (e_c == 3'd4) ? sq_q : SqBits'(d_q);
  assign prod  = SumBits'(sq_q) * SumBits'(mul_b);

  always_comb begin
    case (e_c)
      3'd1:    term_d = SumBits'(d_q);
      3'd2:    term_d = SumBits'(sq_q);
      default: term_d = prod;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) pix_q <= pix_i[PixelBits-1:0];
    if (cmd_i.diff) begin
      d_q  <= (pix_q > opnd) ? (pix_q - opnd) : (opnd - pix_q);
      en_q <= cmd_i.pass_v ? v_en : h_en;
    end
    if (cmd_i.sq)  sq_q   <= SqBits'(d_q) * SqBits'(d_q);
    if (cmd_i.pow) term_q <= term_d;
  end

  // saturating accumulate
  assign sum_w    = {1'b0, acc_q} + {1'b0, term_q};
  assign acc_next = sum_w[SumBits] ? '1 : sum_w[SumBits-1:0];

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = r + RowBits'(1);
    end else begin
      col_d = c + ColBits'(1);
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      win_q[0] <= '0;
      win_q[1] <= '0;
      acc_q    <= '0;
      sat_q    <= 1'b0;
    end else if (cmd_i.load && start_i) begin
      col_q    <= '0;
      row_q    <= '0;
      win_q[0] <= '0;
      win_q[1] <= '0;
      acc_q    <= '0;
      sat_q    <= 1'b0;
    end else if (cmd_i.acc && en_q) begin
      acc_q <= acc_next;
      if (acc_next == '1) sat_q <= 1'b1;
    end else if (cmd_i.wb) begin
      col_q <= col_d;
      row_q <= row_d;
      if (frame_end) begin
        win_q[0] <= '0;
        win_q[1] <= '0;
        acc_q    <= '0;
        sat_q    <= 1'b0;
      end else begin
        win_q[0] <= pix_q;
        win_q[1] <= win_q[0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb && frame_end) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb && frame_end) begin
      out_sum_q <= acc_q;
      out_sat_q <= sat_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_sum_o   = out_sum_q;
  assign m_sat_o   = out_sat_q;

  `BFM_ASSERT_NOW(a_flag_means_max, sat_q, acc_q == '1, "saturation flag without a full sum")
  `BFM_ASSERT_NEXT(a_frame_end_clears, cmd_i.wb && frame_end, (col_q == '0) && (row_q == '0) && (acc_q == '0), "frame state not cleared after result")
  `BFM_ASSERT_NOW(a_no_overwrite, cmd_i.wb && frame_end, !(out_valid_q && !m_ready_i), "pending result overwritten")

endmodule

[rtl/brenner_focus_measure.sv]
// Brenner focus score over one streamed frame.
// Pixels enter on the s_axis channel in raster order, one request each;
// tuser marks the first pixel of a frame and clears position, sum and flag.
// For every interior pixel the absolute difference of the neighbours two
// apart (horizontal, vertical or both, by direction_mode) is raised to
// exponent_power and added into a 64-bit saturating sum.
// One result leaves on m_axis after the last pixel of each frame: tdata is
// the sum, tuser is set when the sum reached its maximum.
// Each pixel is accepted, then takes two passes of four steps through
// the shared diff/square/multiply/accumulate unit (one pass per
// direction term), then writes back the line stores; the line-store read
// is registered during the first pass. No new pixel is accepted until the
// write-back is done, and the last pixel's write-back loads the result.
// If the result is not taken, the block keeps accepting pixels of the next
// frame and only waits at that frame's last pixel until the register frees.
// Config writes on cfg_* are always ready and take effect at once; change
// them only between requests. Reset loads 640x480, horizontal, power 2, and
// clears position and sum; the line stores are not cleared and fill per frame.
module brenner_focus_measure import bfm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DataBits-1:0]    s_axis_tdata,  // pixel_value
  input  logic                   s_axis_tuser,  // frame_start
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SumBits-1:0]     m_axis_tdata,  // focus_sum
  output logic                   m_axis_tuser,  // sum_saturated
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= GeomBits'(640);
      cfg_q.frame_height   <= GeomBits'(480);
      cfg_q.direction_mode <= DirHoriz;
      cfg_q.exponent_power <= ExpBits'(2);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegFrameWidth:    cfg_q.frame_width    <= cfg_data_i[GeomBits-1:0];
        RegFrameHeight:   cfg_q.frame_height   <= cfg_data_i[GeomBits-1:0];
        RegDirectionMode: cfg_q.direction_mode <= cfg_data_i[DirBits-1:0];
        RegExponentPower: cfg_q.exponent_power <= cfg_data_i[ExpBits-1:0];
        default: ;
      endcase
    end
  end

  bfm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  bfm_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .st_o      (st),
    .pix_i     (s_axis_tdata),
    .start_i   (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_sum_o   (m_axis_tdata),
    .m_sat_o   (m_axis_tuser)
  );

endmodule

[tb/sv/brenner_score_checker.sv]
// watches the pixel, result and config channels, keeps its own copy of the
// frame state and compares every score leaving the block with the oldest one
// worked out from the pixels
module brenner_score_checker import bfm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [DataBits-1:0]    s_axis_tdata,   // pixel_value
  input  logic                   s_axis_tuser,   // frame_start
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [SumBits-1:0]     m_axis_tdata,   // focus_sum
  input  logic                   m_axis_tuser,   // sum_saturated
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output int                     mismatch_count_o,
  output int                     pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SumBits-1:0] score;
    logic               saturated;
  } focus_result_t;

  focus_result_t expected_scores[$];
  focus_result_t oldest_score;

  // rows r-2 and r-1 at each column
  logic [PixelBits-1:0] rows_back2[MaxWidth];
  logic [PixelBits-1:0] rows_back1[MaxWidth];
  logic [PixelBits-1:0] pix_back1, pix_back2;
  int unsigned          col_pos, row_pos;
  logic [SumBits-1:0]   score_sum;
  logic                 score_sat;

  logic [GeomBits-1:0]  width_reg, height_reg;
  logic [DirBits-1:0]   dir_reg;
  logic [ExpBits-1:0]   exp_reg;

  function automatic int unsigned clamp_geom(logic [GeomBits-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [SumBits-1:0] raise_power(logic [PixelBits-1:0] d, int unsigned e);
    logic [SumBits-1:0] prod;
    prod = 1;
    for (int unsigned i = 0; i < e; i++) prod = prod * d;
    return prod;
  endfunction

  function automatic void add_term(logic [PixelBits-1:0] a, logic [PixelBits-1:0] b,
                                   int unsigned e);
    logic [PixelBits-1:0] d;
    logic [SumBits:0]     total;
    d = (a > b) ? a - b : b - a;
    total = {1'b0, score_sum} + raise_power(d, e);
    score_sum = total[SumBits] ? '1 : total[SumBits-1:0];
    if (&score_sum) score_sat = 1'b1;
  endfunction

  function automatic void clear_position();
    col_pos   = 0;
    row_pos   = 0;
    score_sum = '0;
    score_sat = 1'b0;
    pix_back1 = '0;
    pix_back2 = '0;
  endfunction

  function automatic void predict_pixel(logic [PixelBits-1:0] pix, logic start);
    int unsigned          w, h, e, c, r;
    logic [PixelBits-1:0] above;
    bit                   row_done;
    w = clamp_geom(width_reg, MaxWidth);
    h = clamp_geom(height_reg, MaxHeight);
    e = (exp_reg == 0) ? 1 : (exp_reg > 4) ? 4 : exp_reg;
    if (start) clear_position();
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;

    // left/right pair centered one column back on an interior row
    if (dir_reg != DirVert && c >= 2 && r >= 1 && r <= h - 2) add_term(pix, pix_back2, e);
    // above/below pair centered one row up on an interior column
    above = rows_back2[c];
    if (dir_reg != DirHoriz && c >= 1 && c <= w - 2 && r >= 2) add_term(pix, above, e);

    rows_back2[c] = rows_back1[c];
    rows_back1[c] = pix;
    pix_back2 = pix_back1;
    pix_back1 = pix;

    row_done = (c >= w - 1);
    if (row_done && r >= h - 1) begin
      expected_scores.push_back('{score: score_sum, saturated: score_sat});
      clear_position();
    end else if (row_done) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = 640;
      height_reg = 480;
      dir_reg    = DirHoriz;
      exp_reg    = 2;
      clear_position();
      expected_scores.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegFrameWidth:    width_reg  = cfg_data_i[GeomBits-1:0];
          RegFrameHeight:   height_reg = cfg_data_i[GeomBits-1:0];
          RegDirectionMode: dir_reg    = cfg_data_i[DirBits-1:0];
          RegExponentPower: exp_reg    = cfg_data_i[ExpBits-1:0];
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_scores.size() == 0) begin
          $error("focus score with no frame pending: focus_sum %0h sum_saturated %0b",
                 m_axis_tdata, m_axis_tuser);
          mismatch_count_o++;
        end else begin
          oldest_score = expected_scores.pop_front();
          if (m_axis_tdata !== oldest_score.score) begin
            $error("focus_sum expected %0h actual %0h", oldest_score.score, m_axis_tdata);
            mismatch_count_o++;
          end
          if (m_axis_tuser !== oldest_score.saturated) begin
            $error("sum_saturated expected %0b actual %0b", oldest_score.saturated,
                   m_axis_tuser);
            mismatch_count_o++;
          end
        end
      end
    end
    pending_count_o = expected_scores.size();
  end

endmodule

[tb/sv/brenner_focus_measure_tb.sv]
module brenner_focus_measure_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  localparam int IdleLimit     = 4000;
  localparam int HoldoffCycles = 400;
  localparam int DrainCycles   = 30;
  localparam int RandomPixels  = 450;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DataBits-1:0]    s_axis_tdata = '0;   // pixel_value
  logic                   s_axis_tuser = 1'b0; // frame_start
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [SumBits-1:0]     m_axis_tdata;        // focus_sum
  logic                   m_axis_tuser;        // sum_saturated
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  int mismatch_count;
  int pending_count;
  int idle_cycles = 0;
  int burst_left = 0;
  bit holdoff_req = 1'b0;
  bit at_origin = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  brenner_focus_measure dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  brenner_score_checker score_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_count)
  );

  // ends the run when no channel has moved for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stretches of steady, random or sparse ready, plus one long hold-off
  initial begin
    int mode, span;
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldoffCycles) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 150);
        for (int k = 0; k < span && !holdoff_req; k++) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic int unsigned frame_pixels(logic [GeomBits-1:0] w, logic [GeomBits-1:0] h);
    int unsigned cw, ch;
    cw = (w < 3) ? 3 : (w > MaxWidth) ? MaxWidth : w;
    ch = (h < 3) ? 3 : (h > MaxHeight) ? MaxHeight : h;
    return cw * ch;
  endfunction

  function automatic logic [DataBits-1:0] make_pixel(int style);
    case (style)
      0:       return DataBits'($urandom_range(0, 65535));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return 16'h8000 ^ 16'($urandom_range(0, 15));
    endcase
  endfunction

  // bursts of requests with random gaps between them
  task automatic send_pixel(input logic [DataBits-1:0] pix, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // one full frame, sometimes after a partial frame that a restart abandons
  task automatic send_frame(input int unsigned n, input bit allow_noise, output int sent);
    int unsigned cut;
    int          style;
    sent = 0;
    if (allow_noise && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, n - 1);
      for (int unsigned i = 0; i < cut; i++) send_pixel(make_pixel(0), $urandom_range(0, 5) == 0);
      sent = cut;
      at_origin = 1'b0;
    end
    style = $urandom_range(0, 2);
    for (int unsigned i = 0; i < n; i++) begin
      send_pixel(make_pixel(style),
                 (i == 0) ? (!at_origin || $urandom_range(0, 7) != 0) : 1'b0);
    end
    at_origin = 1'b1;
    sent += n;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CfgDataBits-1:0] w, input logic [CfgDataBits-1:0] h,
                              input logic [CfgDataBits-1:0] dir,
                              input logic [CfgDataBits-1:0] pwr);
    write_reg(RegFrameWidth, w);
    write_reg(RegFrameHeight, h);
    write_reg(RegDirectionMode, dir);
    write_reg(RegExponentPower, pwr);
    cfg_valid_i <= 1'b0;
  endtask

  // hold the pixel side until every score is out and the block has settled
  task automatic drain_scores();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int                     phase, random_pixels, frames, sent;
    logic [CfgDataBits-1:0] w_val, h_val;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry is far too large, shrink it and keep the reset mode and power
    write_reg(RegFrameWidth, 3);
    write_reg(RegFrameHeight, 3);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 9; i++) send_pixel((i == 5) ? 16'hFFFF : 16'h0001, i == 0);
    drain_scores();

    // clamped geometry, direction three as omni, power zero as one, no frame start
    program_regs(0, 2, 3, 0);
    for (int i = 0; i < 9; i++) send_pixel((i % 4 < 2) ? 16'h0000 : 16'hFFFF, 1'b0);
    drain_scores();

    // full-scale edges at power seven (taken as four) overflow the sum
    program_regs(4, 3, CfgDataBits'(DirHoriz), 7);
    for (int i = 0; i < 12; i++) send_pixel((i % 4 >= 2) ? 16'hFFFF : 16'h0000, i == 0);
    drain_scores();

    phase = 0;
    random_pixels = 0;
    while (random_pixels < RandomPixels || phase <= 2) begin
      if (phase == 2) begin
        w_val = 3;
        h_val = 3;
        frames = 10;
      end else begin
        w_val = $urandom_range(0, 12);
        h_val = $urandom_range(0, 8);
        frames = $urandom_range(2, 5);
      end
      program_regs(w_val, h_val, {11'($urandom_range(0, 2047)), 2'($urandom_range(0, 3))},
                   {10'($urandom_range(0, 1023)), 3'($urandom_range(0, 7))});
      // scores back up behind a long hold-off until the pixel side stalls
      if (phase == 2) holdoff_req = 1'b1;
      for (int f = 0; f < frames; f++) begin
        send_frame(frame_pixels(w_val, h_val), 1'b1, sent);
        random_pixels += sent;
      end
      drain_scores();
      phase++;
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[brenner_focus_measure.f]
+incdir+rtl
rtl/bfm_pkg.sv
rtl/bfm_ctrl.sv
rtl/bfm_datapath.sv
rtl/brenner_focus_measure.sv
tb/sv/brenner_score_checker.sv
tb/sv/brenner_focus_measure_tb.sv
